// ===== rtl/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// Types, codes and helper functions shared by the 32-bit integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DivSteps = DataW;

  typedef enum logic [3:0] {
    FUNC_ADD  = 4'd0,
    FUNC_SUB  = 4'd1,
    FUNC_DIV  = 4'd2,
    FUNC_MUL  = 4'd3,
    FUNC_MOD  = 4'd4,
    FUNC_SHR  = 4'd5,
    FUNC_AND  = 4'd6,
    FUNC_OR   = 4'd7,
    FUNC_XOR  = 4'd8,
    FUNC_SHL  = 4'd9,
    FUNC_ROTL = 4'd10,
    FUNC_ROTR = 4'd11
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OVF     = 2'd1,
    STATUS_DIV0    = 2'd2,
    STATUS_REFUSED = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]       func;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic             negative_operand;
  } in_beat_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [1:0]       status;
  } out_beat_t;

  // State carried by one beat through the pipeline.
  typedef struct packed {
    logic             is_div;
    logic             is_mod;
    logic             a_neg;
    logic             b_neg;
    logic [DataW-1:0] res;
    status_e          status;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] dvs;
  } pipe_t;

  // One restoring division step: shift in the next dividend bit and try
  // to subtract the divisor.
  function automatic pipe_t div_step(pipe_t p);
    pipe_t          n;
    logic [DataW:0] shifted;
    logic [DataW:0] diff;
    n       = p;
    shifted = {p.rem, p.quo[DataW-1]};
    diff    = shifted - {1'b0, p.dvs};
    if (!diff[DataW]) begin
      n.rem = diff[DataW-1:0];
      n.quo = {p.quo[DataW-2:0], 1'b1};
    end else begin
      n.rem = shifted[DataW-1:0];
      n.quo = {p.quo[DataW-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== rtl/int32_alu_with_overflow_flags.sv =====
// ----------------------------------------------------------------------------
// int32_alu_with_overflow_flags
// Pipelined 32-bit integer ALU with signed overflow and divide-by-zero status.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Beat
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i / in_stall_o | in_beat_i  (in_beat_t)
//  out     | output    | out_valid_o / out_stall_i | out_beat_o (out_beat_t)
//
// Every beat passes from acceptance to the output register through one entry
// stage, 32 restoring division stages (one quotient bit each) and one output
// stage. All operations follow the same path, so results leave in order. A new
// beat is accepted every cycle unless a stalled beat holds the output register.
// Reset clears only the valid bits of the stages. When the output register
// holds a beat that is stalled, the whole pipeline holds, so nothing is lost.

module int32_alu_with_overflow_flags (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  ialu_pkg::in_beat_t   in_beat_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output ialu_pkg::out_beat_t  out_beat_o,
  input  logic                 out_stall_i
);

  localparam int unsigned W = ialu_pkg::DataW;
  localparam int unsigned N = ialu_pkg::DivSteps;

  // The pipeline advances unless a finished beat waits at the output.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // Entry stage: quick operations, the multiplier and division setup.
  // --------------------------------------------------------------------------
  ialu_pkg::pipe_t  ent_d, ent_q;
  logic             ent_vld_q;
  logic             is_mul_d, is_mul_q;
  logic [2*W-1:0]   prod_d, prod_q;

  logic [W-1:0]     a, b, sum, dif;
  logic [3:0]       f;
  logic             bitwise, wide_amt;
  logic [4:0]       rot_l, rot_r;
  logic [2*W-1:0]   rot_l_w, rot_r_w;
  // Operands sign-extended so that the full signed product is kept.
  logic signed [2*W-1:0] a_sx, b_sx;

  always_comb begin
    f        = in_beat_i.func;
    a        = in_beat_i.operand_a;
    b        = in_beat_i.operand_b;
    sum      = a + b;
    dif      = a - b;
    wide_amt = |b[W-1:5];
    rot_l    = b[4:0];
    rot_r    = 5'(-b[4:0]);
    rot_l_w  = {a, a} << rot_l;
    rot_r_w  = {a, a} << rot_r;
    bitwise  = (f >= ialu_pkg::FUNC_SHR) && (f <= ialu_pkg::FUNC_ROTR);
    a_sx     = {{W{a[W-1]}}, a};
    b_sx     = {{W{b[W-1]}}, b};
    prod_d   = a_sx * b_sx;

    ent_d        = '0;
    ent_d.status = ialu_pkg::STATUS_OK;
    ent_d.a_neg  = a[W-1];
    ent_d.b_neg  = b[W-1];
    ent_d.quo    = a[W-1] ? (W'(0) - a) : a;
    ent_d.dvs    = b[W-1] ? (W'(0) - b) : b;
    is_mul_d     = 1'b0;

    if (bitwise && in_beat_i.negative_operand) begin
      ent_d.status = ialu_pkg::STATUS_REFUSED;
    end else begin
      case (f)
        ialu_pkg::FUNC_ADD: begin
          if ((a[W-1] ^ sum[W-1]) && (b[W-1] ^ sum[W-1])) begin
            ent_d.status = ialu_pkg::STATUS_OVF;
          end else begin
            ent_d.res = sum;
          end
        end
        ialu_pkg::FUNC_SUB: begin
          if ((a[W-1] ^ b[W-1]) && (a[W-1] ^ dif[W-1])) begin
            ent_d.status = ialu_pkg::STATUS_OVF;
          end else begin
            ent_d.res = dif;
          end
        end
        ialu_pkg::FUNC_DIV, ialu_pkg::FUNC_MOD: begin
          if (b == '0) begin
            ent_d.status = ialu_pkg::STATUS_DIV0;
          end else begin
            ent_d.is_div = 1'b1;
            ent_d.is_mod = (f == ialu_pkg::FUNC_MOD);
          end
        end
        ialu_pkg::FUNC_MUL:  is_mul_d  = 1'b1;
        ialu_pkg::FUNC_SHR:  ent_d.res = wide_amt ? '0 : (a >> b[4:0]);
        ialu_pkg::FUNC_SHL:  ent_d.res = wide_amt ? '0 : (a << b[4:0]);
        ialu_pkg::FUNC_AND:  ent_d.res = a & b;
        ialu_pkg::FUNC_OR:   ent_d.res = a | b;
        ialu_pkg::FUNC_XOR:  ent_d.res = a ^ b;
        ialu_pkg::FUNC_ROTL: ent_d.res = rot_l_w[2*W-1:W];
        ialu_pkg::FUNC_ROTR: ent_d.res = rot_r_w[2*W-1:W];
        default:             ent_d.res = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
    end else if (adv) begin
      ent_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ent_q    <= ent_d;
      is_mul_q <= is_mul_d;
      prod_q   <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Product range check, then the division chain with one bit per stage.
  // --------------------------------------------------------------------------
  ialu_pkg::pipe_t mul_fix;

  always_comb begin
    mul_fix = ent_q;
    if (is_mul_q) begin
      // The product fits when its upper 33 bits are all equal.
      if ((&prod_q[2*W-1:W-1]) || !(|prod_q[2*W-1:W-1])) begin
        mul_fix.res = prod_q[W-1:0];
      end else begin
        mul_fix.status = ialu_pkg::STATUS_OVF;
      end
    end
  end

  ialu_pkg::pipe_t stg_d [N];
  ialu_pkg::pipe_t stg_q [N];
  logic [N-1:0]    stg_vld_q;

  always_comb begin
    stg_d[0] = ialu_pkg::div_step(mul_fix);
    for (int k = 1; k < N; k++) begin
      stg_d[k] = ialu_pkg::div_step(stg_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
    end else if (adv) begin
      stg_vld_q <= {stg_vld_q[N-2:0], ent_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: apply quotient and remainder signs.
  // --------------------------------------------------------------------------
  ialu_pkg::pipe_t     last;
  ialu_pkg::out_beat_t out_d, out_q;
  logic                out_vld_q;

  always_comb begin
    last         = stg_q[N-1];
    out_d.result = last.res;
    out_d.status = last.status;
    if (last.is_div) begin
      if (last.is_mod) begin
        out_d.result = last.a_neg ? (W'(0) - last.rem) : last.rem;
      end else if (last.a_neg ^ last.b_neg) begin
        out_d.result = W'(0) - last.quo;
      end else if (last.quo[W-1]) begin
        // Most negative value divided by minus one.
        out_d.result = '0;
        out_d.status = ialu_pkg::STATUS_OVF;
      end else begin
        out_d.result = last.quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= stg_vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Any status other than ok comes with a zero result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.status == ialu_pkg::STATUS_OK) ||
                    (out_beat_o.result == '0))
    else $error("nonzero result with error status");

  // The input side is stalled only by a held output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A division result leaving the chain never carries a divide-by-zero mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_vld_q[N-1] && last.is_div) |-> (last.status == ialu_pkg::STATUS_OK))
    else $error("division beat with bad status in chain");

endmodule

// ===== dv/int32_alu_with_overflow_flags_tb.sv =====
// ----------------------------------------------------------------------------
// int32_alu_with_overflow_flags_tb
// Self-checking bench for the 32-bit ALU: a queue-fed driver with random
// idle bursts, a monitor with random stall bursts, and a predictor that
// computes the expected result word and status for every accepted beat.
// ----------------------------------------------------------------------------
module int32_alu_with_overflow_flags_tb;

  // The drain wait below leaves margin after the last result.
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned RandomBeats = 1400;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  ialu_pkg::in_beat_t  in_beat;
  logic                in_stall;
  logic                out_valid;
  ialu_pkg::out_beat_t out_beat;
  logic                out_stall;

  // Beats waiting to be driven, and results predicted for accepted beats.
  ialu_pkg::in_beat_t  pending_beats[$];
  ialu_pkg::out_beat_t expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_left;
  int unsigned recv_stall_left;
  bit          idling_enabled;
  bit          hold_sender;

  int32_alu_with_overflow_flags i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_beat_i   (in_beat),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_beat_o  (out_beat),
    .out_stall_i (out_stall)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Computes what the ALU should return for one beat. Arithmetic is done at
  // 64 bits so that the exact signed result can be compared against the
  // 32-bit range.
  function automatic ialu_pkg::out_beat_t alu_predict(ialu_pkg::in_beat_t b);
    ialu_pkg::out_beat_t r;
    logic [31:0]    a;
    logic [31:0]    d;
    logic [31:0]    mag_a;
    logic [31:0]    mag_b;
    logic [31:0]    quo;
    logic [31:0]    rem;
    logic [4:0]     amount;
    longint         wide;
    a        = b.operand_a;
    d        = b.operand_b;
    r.result = '0;
    r.status = ialu_pkg::STATUS_OK;
    if (b.func >= ialu_pkg::FUNC_SHR && b.func <= ialu_pkg::FUNC_ROTR &&
        b.negative_operand) begin
      r.status = ialu_pkg::STATUS_REFUSED;
    end else begin
      case (b.func)
        ialu_pkg::FUNC_ADD, ialu_pkg::FUNC_SUB, ialu_pkg::FUNC_MUL: begin
          if (b.func == ialu_pkg::FUNC_ADD) begin
            wide = longint'($signed(a)) + longint'($signed(d));
          end else if (b.func == ialu_pkg::FUNC_SUB) begin
            wide = longint'($signed(a)) - longint'($signed(d));
          end else begin
            wide = longint'($signed(a)) * longint'($signed(d));
          end
          if (wide > 64'sd2147483647 || wide < -64'sd2147483648) begin
            r.status = ialu_pkg::STATUS_OVF;
          end else begin
            r.result = wide[31:0];
          end
        end
        ialu_pkg::FUNC_DIV, ialu_pkg::FUNC_MOD: begin
          if (d == 0) begin
            r.status = ialu_pkg::STATUS_DIV0;
          end else begin
            // Divide magnitudes, then fix the signs: the quotient truncates
            // toward zero and the remainder follows the dividend.
            mag_a = a[31] ? -a : a;
            mag_b = d[31] ? -d : d;
            quo   = mag_a / mag_b;
            rem   = mag_a % mag_b;
            if (b.func == ialu_pkg::FUNC_MOD) begin
              r.result = a[31] ? -rem : rem;
            end else if (a[31] ^ d[31]) begin
              r.result = -quo;
            end else if (quo[31]) begin
              r.status = ialu_pkg::STATUS_OVF;
            end else begin
              r.result = quo;
            end
          end
        end
        ialu_pkg::FUNC_SHR: r.result = (d >= 32) ? '0 : a >> d;
        ialu_pkg::FUNC_SHL: r.result = (d >= 32) ? '0 : a << d;
        ialu_pkg::FUNC_AND: r.result = a & d;
        ialu_pkg::FUNC_OR:  r.result = a | d;
        ialu_pkg::FUNC_XOR: r.result = a ^ d;
        ialu_pkg::FUNC_ROTL, ialu_pkg::FUNC_ROTR: begin
          amount = (b.func == ialu_pkg::FUNC_ROTL) ? d[4:0] : 5'(-d[4:0]);
          r.result = (a << amount) | (a >> (6'd32 - amount));
          if (amount == 0) r.result = a;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    // Bias toward the edges where overflow and sign handling live.
    case ($urandom_range(0, 7))
      0: w = 32'h8000_0000;
      1: w = 32'hFFFF_FFFF;
      2: w = 32'h7FFF_FFFF;
      3: w = $urandom_range(0, 40);
      4: w = -$urandom_range(0, 40);
      5: w = $urandom() >> $urandom_range(0, 31);
      default: w = $urandom();
    endcase
    return w;
  endfunction

  task automatic queue_beat(logic [3:0] f, logic [31:0] a, logic [31:0] d, logic n);
    ialu_pkg::in_beat_t b;
    b.func             = f;
    b.operand_a        = a;
    b.operand_b        = d;
    b.negative_operand = n;
    pending_beats.push_back(b);
  endtask

  // Driver: presents the head of the queue, holds it while stalled, and
  // inserts random idle bursts while idling is enabled.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_beat        <= '0;
      send_idle_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      // The current beat, if any, was accepted at this edge.
      if (in_valid) begin
        expected_results.push_back(alu_predict(in_beat));
      end
      if (send_idle_left != 0) begin
        send_idle_left <= send_idle_left - 1;
        in_valid       <= 1'b0;
      end else if (idling_enabled && $urandom_range(0, 9) == 0) begin
        send_idle_left <= $urandom_range(0, 16);
        in_valid       <= 1'b0;
      end else if (!hold_sender && pending_beats.size() != 0) begin
        in_beat  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result beat and drives random stalls.
  always @(posedge clk or negedge rst_n) begin
    ialu_pkg::out_beat_t want;
    if (!rst_n) begin
      out_stall       <= 1'b0;
      recv_stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: result=%h status=%0d",
                     out_beat.result, out_beat.status);
        end else begin
          want = expected_results.pop_front();
          if (out_beat.result !== want.result || out_beat.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected result=%h status=%0d, got result=%h status=%0d",
                       want.result, want.status, out_beat.result, out_beat.status);
          end
        end
      end
      if (recv_stall_left != 0) begin
        recv_stall_left <= recv_stall_left - 1;
        out_stall       <= 1'b1;
      end else if (idling_enabled && $urandom_range(0, 9) == 0) begin
        recv_stall_left <= $urandom_range(0, 16);
        out_stall       <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [3:0] f;
    idling_enabled = 1'b1;
    hold_sender    = 1'b0;
    rst_n          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners: overflow on each arithmetic operation, the most
    // negative dividend by minus one, zero divisors, refused bitwise
    // operations, wide shifts, rotate by zero and by 32, unused opcodes.
    queue_beat(ialu_pkg::FUNC_ADD,  32'h7FFF_FFFF, 32'd1,         1'b0);
    queue_beat(ialu_pkg::FUNC_ADD,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    queue_beat(ialu_pkg::FUNC_SUB,  32'h8000_0000, 32'd1,         1'b0);
    queue_beat(ialu_pkg::FUNC_SUB,  32'd0,         32'h8000_0000, 1'b0);
    queue_beat(ialu_pkg::FUNC_MUL,  32'h0001_0000, 32'h0001_0000, 1'b0);
    queue_beat(ialu_pkg::FUNC_MUL,  32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_beat(ialu_pkg::FUNC_MUL,  32'hFFFF_0000, 32'h0000_8000, 1'b0);
    queue_beat(ialu_pkg::FUNC_DIV,  32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_beat(ialu_pkg::FUNC_DIV,  32'hFFFF_FFF9, 32'd2,         1'b0);
    queue_beat(ialu_pkg::FUNC_DIV,  32'd5,         32'd0,         1'b0);
    queue_beat(ialu_pkg::FUNC_MOD,  32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_beat(ialu_pkg::FUNC_MOD,  32'hFFFF_FFF9, 32'd2,         1'b0);
    queue_beat(ialu_pkg::FUNC_MOD,  32'd5,         32'd0,         1'b1);
    queue_beat(ialu_pkg::FUNC_SHR,  32'hFFFF_FFFF, 32'd32,        1'b0);
    queue_beat(ialu_pkg::FUNC_SHL,  32'hFFFF_FFFF, 32'd31,        1'b0);
    queue_beat(ialu_pkg::FUNC_SHL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_beat(ialu_pkg::FUNC_AND,  32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'b1);
    queue_beat(ialu_pkg::FUNC_OR,   32'h0F0F_0000, 32'h0000_F0F0, 1'b0);
    queue_beat(ialu_pkg::FUNC_XOR,  32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
    queue_beat(ialu_pkg::FUNC_ROTL, 32'h8000_0001, 32'd0,         1'b0);
    queue_beat(ialu_pkg::FUNC_ROTL, 32'h8000_0001, 32'd33,        1'b0);
    queue_beat(ialu_pkg::FUNC_ROTR, 32'h8000_0001, 32'd32,        1'b0);
    queue_beat(ialu_pkg::FUNC_ROTR, 32'h8000_0001, 32'd1,         1'b1);
    queue_beat(4'd12,               32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_beat(4'd15,               32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // Let the directed beats drain fully before random traffic starts, so
    // the sender is seen waiting on an empty pipeline at least once.
    wait (pending_beats.size() == 0 && !in_valid);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0);
    hold_sender = 1'b0;

    for (int i = 0; i < RandomBeats; i++) begin
      // Opcodes 12 to 15 are rare; the flag is set only now and then so
      // that bitwise operations mostly go through.
      f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                       : 4'($urandom_range(0, 11));
      queue_beat(f, rand_word(), rand_word(), $urandom_range(0, 3) == 0);
      // The last stretch runs with neither side idling.
      if (i == RandomBeats - 200) begin
        wait (pending_beats.size() == 0);
        idling_enabled = 1'b0;
      end
    end

    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
